// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ===== src/ttrz_pkg.sv =====
// Shared types, widths and codes of the tile rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package ttrz_pkg;
  localparam int TILE_W_DEF = 8;
  localparam int TILE_H_DEF = 8;
  localparam int COORD_W    = 12;
  localparam int Z_W        = 16;
  localparam int WGT_W      = 13;
  localparam int PIX_W      = 3;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int DIFF_W     = 13;
  localparam int MUL_W      = 17;
  localparam int ACC_W      = 36;
  localparam int NUM_W      = 28;
  localparam int NUM_S_W    = NUM_W + 1;
  localparam int FRAC_W     = 12;
  localparam int BOX_W      = 9;

  localparam logic [WGT_W-1:0] ONE_Q12 = WGT_W'(4096);
  localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [3:0] mac_op_t;
  localparam mac_op_t MAC_NONE = 4'd0;
  localparam mac_op_t MAC_D_A  = 4'd1;
  localparam mac_op_t MAC_D_B  = 4'd2;
  localparam mac_op_t MAC_N2_A = 4'd3;
  localparam mac_op_t MAC_N2_B = 4'd4;
  localparam mac_op_t MAC_N1_A = 4'd5;
  localparam mac_op_t MAC_N1_B = 4'd6;
  localparam mac_op_t MAC_Z_A  = 4'd7;
  localparam mac_op_t MAC_Z_B  = 4'd8;
  localparam mac_op_t MAC_Z_C  = 4'd9;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [Z_W-1:0]     v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [Z_W-1:0]     v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [Z_W-1:0]     v2_z;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic signed [Z_W-1:0] frag_depth;
    logic [WGT_W-1:0]      weight_a;
    logic [WGT_W-1:0]      weight_b;
    logic [WGT_W-1:0]      weight_c;
    logic                  is_fragment;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic    load_tri;
    mac_op_t mac_op;
    logic    save_d;
    logic    start_walk;
    logic    save_n2;
    logic    save_n1;
    logic    rd_stored;
    logic    cap_stored;
    logic    div_start;
    logic    commit;
    logic    step;
    logic    finish;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic d_zero;
    logic box_empty;
    logic in_tri;
    logic div_done;
    logic pass;
    logic last_pix;
    logic out_free;
    logic pend_valid;
  } status_t;
endpackage
`default_nettype wire

// ===== src/ttrz_if.sv =====
// Request channel interfaces: triangle input, fragment output, configuration.
`timescale 1ns / 1ps
`default_nettype none
interface ttrz_in_if import ttrz_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [COORD_W-1:0] v0_x;
  logic signed [COORD_W-1:0] v0_y;
  logic signed [Z_W-1:0]     v0_z;
  logic signed [COORD_W-1:0] v1_x;
  logic signed [COORD_W-1:0] v1_y;
  logic signed [Z_W-1:0]     v1_z;
  logic signed [COORD_W-1:0] v2_x;
  logic signed [COORD_W-1:0] v2_y;
  logic signed [Z_W-1:0]     v2_z;
  modport source (output valid, func, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, input ready);
  modport sink (input valid, func, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, output ready);
endinterface

interface ttrz_out_if import ttrz_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [PIX_W-1:0]      pixel_x;
  logic [PIX_W-1:0]      pixel_y;
  logic signed [Z_W-1:0] frag_depth;
  logic [WGT_W-1:0]      weight_a;
  logic [WGT_W-1:0]      weight_b;
  logic [WGT_W-1:0]      weight_c;
  logic                  is_fragment;
  logic                  last;
  modport source (output valid, pixel_x, pixel_y, frag_depth, weight_a, weight_b,
                  weight_c, is_fragment, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, frag_depth, weight_a, weight_b,
                weight_c, is_fragment, last, output ready);
endinterface

interface ttrz_cfg_if import ttrz_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/ttrz_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module ttrz_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== src/ttrz_div.sv =====
// Restoring divider, one quotient bit per cycle, for num <= den.
`timescale 1ns / 1ps
`default_nettype none
module ttrz_div import ttrz_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int Q_W = WGT_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [N_W-1:0] den,
  output logic           done,
  output logic [Q_W-1:0] quot
);
  localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [N_W-1:0]   rem_r, rem_nxt;
  logic [N_W-1:0]   den_r;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             first_r, first_nxt;
  logic             done_r, done_nxt;
  logic [N_W:0]     trial;
  logic             ge;

  assign trial = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    first_nxt = first_r;
    done_nxt  = done_r;
    if (start) begin
      rem_nxt   = num;
      q_nxt     = '0;
      cnt_nxt   = CNT_W'(Q_W - 1);
      run_nxt   = 1'b1;
      first_nxt = 1'b1;
      done_nxt  = 1'b0;
    end else if (run_r) begin
      rem_nxt   = ge ? N_W'(trial - {1'b0, den_r}) : N_W'(trial);
      q_nxt     = {q_r[Q_W-2:0], ge};
      first_nxt = 1'b0;
      cnt_nxt   = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

// ===== src/ttrz_ctrl.sv =====
// Sequencer: triangle setup, pixel walk, clear requests and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module ttrz_ctrl import ttrz_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECODE = 5'd1;
  localparam logic [4:0] S_CLEAR  = 5'd2;
  localparam logic [4:0] S_D1     = 5'd3;
  localparam logic [4:0] S_SAVE_D = 5'd4;
  localparam logic [4:0] S_CHK    = 5'd5;
  localparam logic [4:0] S_E0     = 5'd6;
  localparam logic [4:0] S_E1     = 5'd7;
  localparam logic [4:0] S_E2     = 5'd8;
  localparam logic [4:0] S_E3     = 5'd9;
  localparam logic [4:0] S_E4     = 5'd10;
  localparam logic [4:0] S_TEST   = 5'd11;
  localparam logic [4:0] S_DIV    = 5'd12;
  localparam logic [4:0] S_Z1     = 5'd13;
  localparam logic [4:0] S_Z2     = 5'd14;
  localparam logic [4:0] S_CMP    = 5'd15;
  localparam logic [4:0] S_COMMIT = 5'd16;
  localparam logic [4:0] S_NEXT   = 5'd17;
  localparam logic [4:0] S_FIN    = 5'd18;

  logic [4:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_tri = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.is_clear) begin
          state_nxt = S_CLEAR;
        end else begin
          cmd.mac_op = MAC_D_A;
          state_nxt  = S_D1;
        end
      end
      S_CLEAR: begin
        if (status.out_free) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_D1: begin
        cmd.mac_op = MAC_D_B;
        state_nxt  = S_SAVE_D;
      end
      S_SAVE_D: begin
        cmd.save_d = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (status.d_zero || status.box_empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start_walk = 1'b1;
          state_nxt      = S_E0;
        end
      end
      S_E0: begin
        cmd.mac_op    = MAC_N2_A;
        cmd.rd_stored = 1'b1;
        state_nxt     = S_E1;
      end
      S_E1: begin
        cmd.mac_op     = MAC_N2_B;
        cmd.cap_stored = 1'b1;
        state_nxt      = S_E2;
      end
      S_E2: begin
        cmd.save_n2 = 1'b1;
        cmd.mac_op  = MAC_N1_A;
        state_nxt   = S_E3;
      end
      S_E3: begin
        cmd.mac_op = MAC_N1_B;
        state_nxt  = S_E4;
      end
      S_E4: begin
        cmd.save_n1 = 1'b1;
        state_nxt   = S_TEST;
      end
      S_TEST: begin
        if (status.in_tri) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.mac_op = MAC_Z_A;
          state_nxt  = S_Z1;
        end
      end
      S_Z1: begin
        cmd.mac_op = MAC_Z_B;
        state_nxt  = S_Z2;
      end
      S_Z2: begin
        cmd.mac_op = MAC_Z_C;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        state_nxt = status.pass ? S_COMMIT : S_NEXT;
      end
      S_COMMIT: begin
        if (!status.pend_valid || status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status.last_pix) begin
          state_nxt = S_FIN;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_E0;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/ttrz_dpath.sv =====
// Datapath: vertex registers, shared MAC, dividers, depth store, result buffering.
`timescale 1ns / 1ps
`default_nettype none
module ttrz_dpath import ttrz_pkg::*; #(
  parameter int TILE_W = TILE_W_DEF,
  parameter int TILE_H = TILE_H_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  in_item_t             in_item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);
  localparam int DEPTH  = TILE_W * TILE_H;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b, input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b, input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  logic [CFG_W-1:0] tw_r, th_r;
  in_item_t         tri_r;

  logic signed [ACC_W-1:0]   acc_r;
  logic [NUM_W-1:0]          d_abs_r;
  logic                      d_neg_r;
  logic signed [BOX_W-1:0]   x0_r, x1_r, y0_r, y1_r;
  logic [PIX_W-1:0]          px_r, py_r;
  logic signed [NUM_S_W-1:0] n1_r, n2_r;
  logic signed [Z_W-1:0]     stored_r;
  logic                      sv_r;
  logic [DEPTH-1:0]          zv_r;
  out_item_t                 pend_r;
  logic                      pend_valid_r;
  out_item_t                 out_r;
  logic                      out_valid_r;

  // edge and setup operands
  logic signed [DIFF_W-1:0] dxb, dxc, dyb, dyc, axp, ayq, pc, qc;
  assign pc  = $signed({{(DIFF_W-PIX_W-4){1'b0}}, px_r, 4'b0});
  assign qc  = $signed({{(DIFF_W-PIX_W-4){1'b0}}, py_r, 4'b0});
  assign dxb = DIFF_W'(tri_r.v1_x) - DIFF_W'(tri_r.v0_x);
  assign dxc = DIFF_W'(tri_r.v2_x) - DIFF_W'(tri_r.v0_x);
  assign dyb = DIFF_W'(tri_r.v1_y) - DIFF_W'(tri_r.v0_y);
  assign dyc = DIFF_W'(tri_r.v2_y) - DIFF_W'(tri_r.v0_y);
  assign axp = DIFF_W'(tri_r.v0_x) - pc;
  assign ayq = DIFF_W'(tri_r.v0_y) - qc;

  logic [WGT_W-1:0] wb, wc, wa;
  logic             done_b, done_c;
  assign wa = WGT_W'(ONE_Q12 - wb - wc);

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_e;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mac_op)
      MAC_D_A:  begin ma = MUL_W'(dyc); mb = MUL_W'(dxb); end
      MAC_D_B:  begin ma = MUL_W'(dyb); mb = MUL_W'(dxc); end
      MAC_N2_A: begin ma = MUL_W'(dyb); mb = MUL_W'(axp); end
      MAC_N2_B: begin ma = MUL_W'(ayq); mb = MUL_W'(dxb); end
      MAC_N1_A: begin ma = MUL_W'(ayq); mb = MUL_W'(dxc); end
      MAC_N1_B: begin ma = MUL_W'(dyc); mb = MUL_W'(axp); end
      MAC_Z_A:  begin ma = MUL_W'(tri_r.v0_z); mb = $signed({{(MUL_W-WGT_W){1'b0}}, wa}); end
      MAC_Z_B:  begin ma = MUL_W'(tri_r.v1_z); mb = $signed({{(MUL_W-WGT_W){1'b0}}, wb}); end
      MAC_Z_C:  begin ma = MUL_W'(tri_r.v2_z); mb = $signed({{(MUL_W-WGT_W){1'b0}}, wc}); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  assign prod   = ma * mb;
  assign prod_e = ACC_W'(prod);

  // bounding box, clipped to the tile in use
  logic [CFG_W-1:0]        w_sat, h_sat;
  logic signed [BOX_W-1:0] fx0, fx1, fy0, fy1, wlim, hlim;
  assign w_sat = (tw_r > CFG_W'(TILE_W)) ? CFG_W'(TILE_W) : tw_r;
  assign h_sat = (th_r > CFG_W'(TILE_H)) ? CFG_W'(TILE_H) : th_r;
  assign wlim  = $signed({{(BOX_W-CFG_W){1'b0}}, w_sat}) - BOX_W'(1);
  assign hlim  = $signed({{(BOX_W-CFG_W){1'b0}}, h_sat}) - BOX_W'(1);
  assign fx0   = BOX_W'(min3(tri_r.v0_x, tri_r.v1_x, tri_r.v2_x) >>> 4);
  assign fx1   = BOX_W'(max3(tri_r.v0_x, tri_r.v1_x, tri_r.v2_x) >>> 4);
  assign fy0   = BOX_W'(min3(tri_r.v0_y, tri_r.v1_y, tri_r.v2_y) >>> 4);
  assign fy1   = BOX_W'(max3(tri_r.v0_y, tri_r.v1_y, tri_r.v2_y) >>> 4);

  logic signed [ACC_W-1:0] acc_neg, n_norm;
  assign acc_neg = -acc_r;
  assign n_norm  = d_neg_r ? acc_neg : acc_r;

  logic signed [NUM_S_W:0] n0;
  assign n0 = $signed({2'b0, d_abs_r}) - (NUM_S_W+1)'(n1_r) - (NUM_S_W+1)'(n2_r);

  logic signed [ACC_W-1:0] stored_q;
  logic signed [ACC_W-1:0] acc_abs_sh;
  logic signed [Z_W-1:0]   depth_t;
  assign stored_q   = $signed({stored_r, {FRAC_W{1'b0}}});
  assign acc_abs_sh = (acc_r[ACC_W-1] ? acc_neg : acc_r) >>> FRAC_W;
  assign depth_t    = acc_r[ACC_W-1] ? Z_W'(-acc_abs_sh) : Z_W'(acc_abs_sh);

  logic [ADDR_W-1:0] addr;
  logic [Z_W-1:0]    ram_q;
  assign addr = ADDR_W'(int'(py_r) * TILE_W + int'(px_r));

  ttrz_ram #(.WIDTH(Z_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(addr),
    .wdata(depth_t),
    .re   (cmd.rd_stored),
    .raddr(addr),
    .rdata(ram_q)
  );

  ttrz_div #(.N_W(NUM_W), .Q_W(WGT_W)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(n1_r[NUM_W-1:0]), .den(d_abs_r), .done(done_b), .quot(wb)
  );

  ttrz_div #(.N_W(NUM_W), .Q_W(WGT_W)) u_div_c (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(n2_r[NUM_W-1:0]), .den(d_abs_r), .done(done_c), .quot(wc)
  );

  out_item_t frag, marker, push_item;
  logic      push, out_free;

  always_comb begin
    frag             = '0;
    frag.pixel_x     = px_r;
    frag.pixel_y     = py_r;
    frag.frag_depth  = depth_t;
    frag.weight_a    = wa;
    frag.weight_b    = wb;
    frag.weight_c    = wc;
    frag.is_fragment = 1'b1;
    marker           = '0;
    marker.last      = 1'b1;
    push             = 1'b0;
    push_item        = pend_r;
    if (cmd.clear) begin
      push      = 1'b1;
      push_item = marker;
    end else if (cmd.commit && pend_valid_r) begin
      push      = 1'b1;
      push_item = pend_r;
    end else if (cmd.finish) begin
      push = 1'b1;
      if (pend_valid_r) begin
        push_item      = pend_r;
        push_item.last = 1'b1;
      end else begin
        push_item = marker;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r         <= CFG_W'(TILE_W_DEF);
      th_r         <= CFG_W'(TILE_H_DEF);
      zv_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == REG_TILE_WIDTH) begin
        tw_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_TILE_HEIGHT) begin
        th_r <= cfg_data;
      end
      if (cmd.clear) begin
        zv_r <= '0;
      end else if (cmd.commit) begin
        zv_r[addr] <= 1'b1;
      end
      if (cmd.commit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.load_tri) begin
      tri_r <= in_item;
    end
    case (cmd.mac_op)
      MAC_D_A, MAC_N2_A, MAC_N1_A, MAC_Z_A: acc_r <= prod_e;
      MAC_D_B, MAC_N2_B, MAC_N1_B:          acc_r <= acc_r - prod_e;
      MAC_Z_B, MAC_Z_C:                     acc_r <= acc_r + prod_e;
      default:                              acc_r <= acc_r;
    endcase
    if (cmd.save_d) begin
      d_neg_r <= acc_r[ACC_W-1];
      d_abs_r <= NUM_W'(acc_r[ACC_W-1] ? acc_neg : acc_r);
      x0_r    <= fx0[BOX_W-1] ? '0 : fx0;
      x1_r    <= (fx1 > wlim) ? wlim : fx1;
      y0_r    <= fy0[BOX_W-1] ? '0 : fy0;
      y1_r    <= (fy1 > hlim) ? hlim : fy1;
    end
    if (cmd.start_walk) begin
      px_r <= x0_r[PIX_W-1:0];
      py_r <= y0_r[PIX_W-1:0];
    end else if (cmd.step) begin
      if (py_r == y1_r[PIX_W-1:0]) begin
        py_r <= y0_r[PIX_W-1:0];
        px_r <= px_r + PIX_W'(1);
      end else begin
        py_r <= py_r + PIX_W'(1);
      end
    end
    if (cmd.save_n2) begin
      n2_r <= n_norm[NUM_S_W-1:0];
    end
    if (cmd.save_n1) begin
      n1_r <= n_norm[NUM_S_W-1:0];
    end
    if (cmd.rd_stored) begin
      sv_r <= zv_r[addr];
    end
    if (cmd.cap_stored) begin
      stored_r <= sv_r ? $signed(ram_q) : Z_MIN;
    end
    if (cmd.commit) begin
      pend_r <= frag;
    end
    if (push) begin
      out_r <= push_item;
    end
  end

  always_comb begin
    status            = '0;
    status.is_clear   = tri_r.func;
    status.d_zero     = (d_abs_r == '0);
    status.box_empty  = (x0_r > x1_r) || (y0_r > y1_r);
    status.in_tri     = !n1_r[NUM_S_W-1] && !n2_r[NUM_S_W-1] && !n0[NUM_S_W];
    status.div_done   = done_b && done_c;
    status.pass       = acc_r > stored_q;
    status.last_pix   = (px_r == x1_r[PIX_W-1:0]) && (py_r == y1_r[PIX_W-1:0]);
    status.out_free   = out_free;
    status.pend_valid = pend_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

// ===== src/triangle_tile_rasterizer_zbuffer_core.sv =====
// Top level of the tile rasterizer with depth store.
// One triangle per request: after acceptance, setup takes two MAC steps for
// the doubled area, the bounding box clip and the empty check; then each pixel
// of the clipped box takes the edge MAC steps and an inside test, and a pixel
// inside the triangle also takes a restoring division (13 quotient bits, both
// weights in parallel) and three depth MAC steps; a last step hands off the
// final result. The depth store valid bits are dropped at once, so reset
// needs no clearing pass. Fragments are held one deep so that the final one
// can be flagged last; a finished result waits in the output register while
// the next pixel works.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module triangle_tile_rasterizer_zbuffer_core import ttrz_pkg::*; #(
  parameter int TILE_W = TILE_W_DEF,
  parameter int TILE_H = TILE_H_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ttrz_in_if.sink   in_ch,
  ttrz_out_if.source out_ch,
  ttrz_cfg_if.sink  cfg_ch
);
  cmd_t      cmd;
  status_t   status;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  assign in_item.func = in_ch.func;
  assign in_item.v0_x = in_ch.v0_x;
  assign in_item.v0_y = in_ch.v0_y;
  assign in_item.v0_z = in_ch.v0_z;
  assign in_item.v1_x = in_ch.v1_x;
  assign in_item.v1_y = in_ch.v1_y;
  assign in_item.v1_z = in_ch.v1_z;
  assign in_item.v2_x = in_ch.v2_x;
  assign in_item.v2_y = in_ch.v2_y;
  assign in_item.v2_z = in_ch.v2_z;

  assign cfg_ch.ready = 1'b1;

  ttrz_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .status  (status),
    .cmd     (cmd)
  );

  ttrz_dpath #(.TILE_W(TILE_W), .TILE_H(TILE_H)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_item  (in_item),
    .cfg_valid(cfg_ch.valid),
    .cfg_index(cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .out_item (out_item)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.pixel_x     = out_item.pixel_x;
  assign out_ch.pixel_y     = out_item.pixel_y;
  assign out_ch.frag_depth  = out_item.frag_depth;
  assign out_ch.weight_a    = out_item.weight_a;
  assign out_ch.weight_b    = out_item.weight_b;
  assign out_ch.weight_c    = out_item.weight_c;
  assign out_ch.is_fragment = out_item.is_fragment;
  assign out_ch.last        = out_item.last;

  `ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")
  `ASSERT_HOLDS(a_commit_passes, clk, rst_n, !cmd.commit || status.pass, "depth write without depth pass")
  `ASSERT_HOLDS(a_push_has_room, clk, rst_n, !(cmd.finish || cmd.clear) || status.out_free, "result overwritten")
  `ASSERT_HOLDS(a_weights_sum, clk, rst_n, !(out_ch.valid && out_ch.is_fragment) || ((14'(out_ch.weight_a) + 14'(out_ch.weight_b) + 14'(out_ch.weight_c)) == 14'd4096), "weights do not sum to one")
endmodule
`default_nettype wire

// ===== sim/triangle_tile_rasterizer_zbuffer_core_test.sv =====
// Randomised and directed regression of the tile rasterizer with depth store.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tile_rasterizer_zbuffer_core_test;
  import ttrz_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  ttrz_in_if  in_ch ();
  ttrz_out_if out_ch ();
  ttrz_cfg_if cfg_ch ();

  triangle_tile_rasterizer_zbuffer_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // shadow state of the block
  logic signed [Z_W-1:0] zbuf [0:63];
  int unsigned cols_in_use, rows_in_use;

  in_item_t  tri_queue[$];
  out_item_t frag_queue[$];
  int unsigned send_idle_pct, sink_stall_pct;
  int unsigned mismatches;
  int unsigned cycle_count;
  logic feed_on;

  function automatic longint floor_px(longint v);
    if (v >= 0) return v / 16;
    return -((-v + 15) / 16);
  endfunction

  function automatic out_item_t marker();
    out_item_t m;
    m = '0;
    m.last = 1'b1;
    return m;
  endfunction

  task automatic rasterize(input in_item_t t);
    longint ax, ay, az, bx, by, bz, cx, cy, cz, d, dd, w, h;
    longint x0, x1, y0, y1, px, py, p, q, n0, n1, n2, wa, wb, wc, zs, tz;
    int produced;
    out_item_t r;
    produced = 0;
    if (t.func) begin
      for (int i = 0; i < 64; i++) zbuf[i] = Z_MIN;
      frag_queue.push_back(marker());
      return;
    end
    ax = t.v0_x; ay = t.v0_y; az = t.v0_z;
    bx = t.v1_x; by = t.v1_y; bz = t.v1_z;
    cx = t.v2_x; cy = t.v2_y; cz = t.v2_z;
    d = (cy - ay) * (bx - ax) - (by - ay) * (cx - ax);
    if (d == 0) begin
      frag_queue.push_back(marker());
      return;
    end
    w = cols_in_use > 8 ? 8 : cols_in_use;
    h = rows_in_use > 8 ? 8 : rows_in_use;
    x0 = floor_px(ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx));
    x1 = floor_px(ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx));
    y0 = floor_px(ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy));
    y1 = floor_px(ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy));
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > w - 1) x1 = w - 1;
    if (y1 > h - 1) y1 = h - 1;
    for (px = x0; px <= x1; px++) begin
      for (py = y0; py <= y1; py++) begin
        p = px * 16; q = py * 16;
        n2 = (by - ay) * (ax - p) - (ay - q) * (bx - ax);
        n1 = (ay - q) * (cx - ax) - (cy - ay) * (ax - p);
        dd = d;
        if (dd < 0) begin
          dd = -dd; n1 = -n1; n2 = -n2;
        end
        n0 = dd - n1 - n2;
        if (n0 < 0 || n1 < 0 || n2 < 0) continue;
        wb = n1 * 4096 / dd;
        wc = n2 * 4096 / dd;
        wa = 4096 - wb - wc;
        zs = az * wa + bz * wb + cz * wc;
        if (zs > longint'(zbuf[py * 8 + px]) * 4096) begin
          tz = zs >= 0 ? zs / 4096 : -((-zs) / 4096);
          zbuf[py * 8 + px] = tz[Z_W-1:0];
          r = '0;
          r.pixel_x = px[PIX_W-1:0];
          r.pixel_y = py[PIX_W-1:0];
          r.frag_depth = tz[Z_W-1:0];
          r.weight_a = wa[WGT_W-1:0];
          r.weight_b = wb[WGT_W-1:0];
          r.weight_c = wc[WGT_W-1:0];
          r.is_fragment = 1'b1;
          frag_queue.push_back(r);
          produced++;
        end
      end
    end
    if (produced == 0) frag_queue.push_back(marker());
    else frag_queue[$].last = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (feed_on && tri_queue.size() > 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      {in_ch.func, in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y,
       in_ch.v1_z, in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} <= tri_queue.pop_front();
      in_ch.valid <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    in_item_t t;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      t = {in_ch.func, in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y,
           in_ch.v1_z, in_ch.v2_x, in_ch.v2_y, in_ch.v2_z};
      rasterize(t);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.pixel_x, out_ch.pixel_y, out_ch.frag_depth, out_ch.weight_a,
               out_ch.weight_b, out_ch.weight_c, out_ch.is_fragment, out_ch.last};
        if (frag_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = frag_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      out_ch.ready <= $urandom_range(99) >= sink_stall_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                        int x2, int y2, int z2);
    in_item_t t;
    t.func = 1'b0;
    t.v0_x = COORD_W'(x0); t.v0_y = COORD_W'(y0); t.v0_z = Z_W'(z0);
    t.v1_x = COORD_W'(x1); t.v1_y = COORD_W'(y1); t.v1_z = Z_W'(z1);
    t.v2_x = COORD_W'(x2); t.v2_y = COORD_W'(y2); t.v2_z = Z_W'(z2);
    return t;
  endfunction

  function automatic in_item_t random_tri();
    in_item_t t;
    int unsigned k;
    logic [127:0] raw;
    t = make_tri($urandom_range(160) - 16, $urandom_range(160) - 16, $urandom,
                 $urandom_range(160) - 16, $urandom_range(160) - 16, $urandom,
                 $urandom_range(160) - 16, $urandom_range(160) - 16, $urandom);
    k = $urandom_range(9);
    if (k == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(in_item_t)-1:0];
    end
    if (k == 1) t.func = 1'b1;
    if (k == 0) t.func = 1'b0;
    return t;
  endfunction

  task automatic drain();
    while (tri_queue.size() > 0 || in_ch.valid || frag_queue.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_ch.index <= idx;
    cfg_ch.data <= val[CFG_W-1:0];
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_TILE_WIDTH) cols_in_use = val[CFG_W-1:0];
    else rows_in_use = val[CFG_W-1:0];
  endtask

  initial begin
    int unsigned phase_w [0:4];
    int unsigned phase_h [0:4];
    phase_w = '{8, 1, 15, 0, 5};
    phase_h = '{8, 1, 15, 3, 0};
    in_ch.valid = 1'b0;
    {in_ch.func, in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y,
     in_ch.v1_z, in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TILE_WIDTH;
    cfg_ch.data = '0;
    for (int i = 0; i < 64; i++) zbuf[i] = Z_MIN;
    cols_in_use = 8; rows_in_use = 8;
    mismatches = 0; cycle_count = 0;
    send_idle_pct = 0; sink_stall_pct = 0;
    feed_on = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    tri_queue.push_back(make_tri(0, 0, 100, 128, 0, 200, 0, 128, 300));
    tri_queue.push_back(make_tri(0, 0, 50, 128, 0, 50, 0, 128, 50));
    tri_queue.push_back(make_tri(0, 0, 32767, 0, 128, 32767, 128, 0, 32767));
    tri_queue.push_back(make_tri(0, 0, 1, 16, 16, 1, 32, 32, 1));
    tri_queue.push_back(make_tri(-2048, -2048, -32768, 2047, -2048, -32768,
                                 -2048, 2047, -32768));
    tri_queue.push_back(make_tri(2047, 2047, 5, -2048, 2047, -5, 2047, -2048, 7));
    tri_queue.push_back(make_tri(-100, -100, 0, -90, -100, 0, -100, -90, 0));
    tri_queue.push_back(make_tri(8, 8, -3000, 120, 20, 4000, 40, 110, -32768));
    tri_queue.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_queue.push_back(in_item_t'({1'b1, 120'd0}));
    tri_queue.push_back(make_tri(0, 0, -32768, 128, 0, -32768, 0, 128, -32768));
    tri_queue.push_back(make_tri(0, 0, -20000, 128, 128, -20000, 0, 128, -20000));
    tri_queue.push_back(in_item_t'({1'b1, {120{1'b1}}}));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_TILE_WIDTH, phase_w[ph]);
      write_reg(REG_TILE_HEIGHT, phase_h[ph]);
      case (ph)
        1: send_idle_pct = 60;
        2: begin
          send_idle_pct = 0; sink_stall_pct = 60;
        end
        3: begin
          send_idle_pct = 15; sink_stall_pct = 15;
        end
        default: begin
          send_idle_pct = 0; sink_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < 26; i++) tri_queue.push_back(random_tri());
      if (ph == 0) begin
        // hold the sender back until the output is empty
        while (tri_queue.size() > 13) @(posedge clk);
        feed_on <= 1'b0;
        while (in_ch.valid || frag_queue.size() > 0) @(posedge clk);
        feed_on <= 1'b1;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
